>>> rtl/core/lp_pkg.sv
// lp_pkg: shared types and constants of the line paginator.
// Used by lp_queue, lp_front, lp_back and line_paginator.
package lp_pkg;
	localparam int CNT_W = 7;
	localparam logic [10:0] MaxColumns = 11'd1024;
	localparam int FLAG_BREAK = 0;
	localparam int FLAG_FCOL = 1;
	localparam int FLAG_FPAGE = 2;
	localparam logic REG_PAGE_HEIGHT = 1'b0;
	localparam logic REG_COLUMNS = 1'b1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_INVALID = 2'd1,
		ST_NO_BREAK = 2'd2
	} status_t;

	typedef struct packed {
		logic [23:0] lead;
		logic [2:0]  flags;
		logic [30:0] prefix;
		logic [30:0] top;
		logic [30:0] bot;
	} line_word_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             err;
		logic [30:0]      total;
	} run_t;

	typedef struct packed {
		logic [5:0]  page;
		logic [9:0]  column;
		logic [23:0] y;
	} place_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOADS,
		BK_SCAN,
		BK_PLACE,
		BK_EMIT
	} bk_state_t;
endpackage

>>> rtl/core/lp_ram.sv
// lp_ram: generic single write port RAM, registered write-first read.
// No dependencies.
module lp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && waddr == raddr) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> rtl/core/lp_queue.sv
// lp_queue: two-entry request queue between loader and pagination engine.
// Depends on lp_pkg.
module lp_queue import lp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  run_t din,
	input  logic pop,
	output logic valid,
	output run_t dout,
	output logic full
);
	run_t       slot_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign valid = cnt_q != 2'd0;
	assign full  = cnt_q == 2'd2;
	assign dout  = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				slot_q[wptr_q] <= din;
				wptr_q <= ~wptr_q;
			end
			if (pop && valid) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && valid) ? 1 : 0);
		end
	end
endmodule

>>> rtl/core/lp_front.sv
// lp_front: accepts lines, checks them, writes the line store and
// queues one run request per set. Depends on lp_pkg.
module lp_front import lp_pkg::*; #(
	parameter int MAX_LINES = 64,
	localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [23:0]      line_height,
	input  logic [23:0]      space_above,
	input  logic [23:0]      lead_space,
	input  logic             break_allowed,
	input  logic             force_new_column,
	input  logic             force_new_page,
	input  logic             last_line,
	input  logic             release_set,
	output logic             we,
	output logic [LW-1:0]    waddr,
	output line_word_t       wdata,
	output logic             push,
	output run_t             run
);
	logic [CNT_W-1:0] cnt_q, cnt_nx;
	logic             err_q, err_nx, open_q, accept, room, bad;
	logic [30:0]      pre_q, top, bot;

	assign busy   = ~open_q;
	assign accept = start & open_q;
	assign room   = cnt_q < CNT_W'(MAX_LINES);
	assign bad    = (line_height == 24'd0) || (force_new_column && force_new_page);
	assign top    = pre_q + 31'(space_above);
	assign bot    = top + 31'(line_height);
	assign err_nx = err_q | ~room | bad;
	assign cnt_nx = room ? cnt_q + CNT_W'(1) : cnt_q;

	assign we    = accept & room;
	assign waddr = cnt_q[LW-1:0];
	always_comb begin
		wdata.lead   = lead_space;
		wdata.flags  = {force_new_page, force_new_column, break_allowed};
		wdata.prefix = pre_q;
		wdata.top    = top;
		wdata.bot    = bot;
	end

	assign push      = accept & last_line;
	assign run.count = cnt_nx;
	assign run.err   = err_nx;
	assign run.total = room ? bot : pre_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			err_q  <= 1'b0;
			pre_q  <= '0;
			open_q <= 1'b1;
		end else begin
			if (accept) begin
				if (last_line) begin
					cnt_q  <= '0;
					err_q  <= 1'b0;
					pre_q  <= '0;
					open_q <= 1'b0;
				end else begin
					cnt_q <= cnt_nx;
					err_q <= err_nx;
					if (room) begin
						pre_q <= bot;
					end
				end
			end
			if (release_set) begin
				open_q <= 1'b1;
			end
		end
	end
endmodule

>>> rtl/core/lp_back.sv
// lp_back: fragment search, placement and result stream.
// Depends on lp_pkg and lp_ram (placement store).
module lp_back import lp_pkg::*; #(
	parameter int MAX_LINES = 64,
	localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  run_t        q_run,
	output logic        pop,
	output logic [LW-1:0] line_raddr,
	input  line_word_t  line_rdata,
	input  logic [23:0] page_height,
	input  logic [10:0] columns_per_page,
	output logic        release_set,
	output logic        result_valid,
	output logic [5:0]  line_number,
	output logic [5:0]  page_number,
	output logic [9:0]  column_number,
	output logic [23:0] y_offset,
	output logic [1:0]  status,
	output logic [6:0]  fragment_total,
	output logic [6:0]  page_total,
	output logic        final_result
);
	bk_state_t        state_q, state_d;
	logic [CNT_W-1:0] n_q, s_q, m_q, end_q, brk_q, i_q, page_q, frag_q;
	logic [9:0]       col_q;
	logic             brk_v_q, first_q;
	logic [23:0]      lead_q;
	logic [30:0]      top_q, total_q, pm;
	logic [32:0]      r_q;
	logic [CNT_W-1:0] laddr, paddr, brk_now, end_now;
	logic             place_we, fits, at_end, is_brk, is_forced, brk_now_v;
	logic             scan_done, end_ok, over, last_in_frag, last_i, cfg_bad, run_bad;
	logic [23:0]      y_now;
	place_t           pwdata, prdata;
	line_word_t       w;

	assign w = line_rdata;

	lp_ram #(.WIDTH($bits(place_t)), .DEPTH(MAX_LINES)) u_place (
		.clk   (clk),
		.we    (place_we),
		.waddr (i_q[LW-1:0]),
		.wdata (pwdata),
		.raddr (paddr[LW-1:0]),
		.rdata (prdata)
	);

	assign cfg_bad = (page_height == 24'd0) || (columns_per_page == 11'd0)
		|| (columns_per_page > MaxColumns);
	assign run_bad = q_run.err || (q_run.count == '0) || cfg_bad;

	assign at_end    = m_q == n_q;
	assign pm        = at_end ? total_q : w.prefix;
	assign fits      = (33'(pm) + 33'(lead_q)) <= r_q;
	assign is_brk    = !at_end && (w.flags != 3'd0);
	assign is_forced = !at_end && (w.flags[FLAG_FCOL] || w.flags[FLAG_FPAGE]);
	assign brk_now_v = brk_v_q | (fits & is_brk);
	assign brk_now   = (fits && is_brk) ? m_q : brk_q;
	assign scan_done = !fits || at_end || is_forced;
	assign end_ok    = (fits && at_end) || brk_now_v;
	assign end_now   = (fits && at_end) ? n_q : brk_now;

	assign y_now        = 24'(w.top + 31'(lead_q) - top_q);
	assign over         = (33'(w.bot) + 33'(lead_q)) > r_q;
	assign last_in_frag = (i_q + CNT_W'(1)) == end_q;
	assign last_i       = (i_q + CNT_W'(1)) == n_q;

	assign pwdata.page   = page_q[5:0];
	assign pwdata.column = col_q;
	assign pwdata.y      = y_now;
	assign line_raddr    = laddr[LW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (q_valid) state_d = run_bad ? BK_IDLE : BK_LOADS;
			BK_LOADS: state_d = BK_SCAN;
			BK_SCAN:  if (scan_done) state_d = end_ok ? BK_PLACE : BK_IDLE;
			BK_PLACE: begin
				if (over) state_d = BK_IDLE;
				else if (last_in_frag) state_d = (end_q == n_q) ? BK_EMIT : BK_LOADS;
			end
			BK_EMIT:  if (last_i) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop         = 1'b0;
		laddr       = '0;
		paddr       = '0;
		place_we    = 1'b0;
		release_set = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop         = q_valid;
				release_set = q_valid && run_bad;
			end
			BK_LOADS: laddr = s_q + CNT_W'(1);
			BK_SCAN: begin
				laddr       = scan_done ? s_q : m_q + CNT_W'(1);
				release_set = scan_done && !end_ok;
			end
			BK_PLACE: begin
				laddr       = last_in_frag ? end_q : i_q + CNT_W'(1);
				place_we    = !over;
				release_set = over;
			end
			BK_EMIT: begin
				paddr       = i_q + CNT_W'(1);
				release_set = last_i;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			n_q <= '0; s_q <= '0; m_q <= '0; end_q <= '0; brk_q <= '0; i_q <= '0;
			page_q <= '0; frag_q <= '0; col_q <= '0; brk_v_q <= 1'b0; first_q <= 1'b1;
			lead_q <= '0; top_q <= '0; total_q <= '0; r_q <= '0;
			result_valid <= 1'b0; line_number <= '0; page_number <= '0;
			column_number <= '0; y_offset <= '0; status <= ST_OK;
			fragment_total <= '0; page_total <= '0; final_result <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= 1'b0;
			unique case (state_q)
				BK_IDLE: begin
					if (q_valid) begin
						n_q     <= q_run.count;
						total_q <= q_run.total;
						s_q     <= '0;
						page_q  <= '0;
						col_q   <= '0;
						frag_q  <= '0;
						first_q <= 1'b1;
						if (run_bad) begin
							result_valid <= 1'b1; line_number <= '0; page_number <= '0;
							column_number <= '0; y_offset <= '0; status <= ST_INVALID;
							fragment_total <= '0; page_total <= '0; final_result <= 1'b1;
						end
					end
				end
				BK_LOADS: begin
					if (!first_q) begin
						if (w.flags[FLAG_FPAGE] || ({1'b0, col_q} + 11'd1) == columns_per_page) begin
							page_q <= page_q + CNT_W'(1);
							col_q  <= '0;
						end else begin
							col_q <= col_q + 10'd1;
						end
					end
					lead_q  <= w.lead;
					top_q   <= w.top;
					r_q     <= 33'(page_height) + 33'(w.top);
					m_q     <= s_q + CNT_W'(1);
					brk_v_q <= 1'b0;
				end
				BK_SCAN: begin
					if (!scan_done) begin
						m_q     <= m_q + CNT_W'(1);
						brk_v_q <= brk_now_v;
						brk_q   <= brk_now;
					end else begin
						end_q <= end_now;
						i_q   <= s_q;
						if (!end_ok) begin
							result_valid <= 1'b1; line_number <= '0; page_number <= '0;
							column_number <= '0; y_offset <= '0; status <= ST_NO_BREAK;
							fragment_total <= '0; page_total <= '0; final_result <= 1'b1;
						end
					end
				end
				BK_PLACE: begin
					if (over) begin
						result_valid <= 1'b1; line_number <= '0; page_number <= '0;
						column_number <= '0; y_offset <= '0; status <= ST_INVALID;
						fragment_total <= '0; page_total <= '0; final_result <= 1'b1;
					end else if (last_in_frag) begin
						frag_q  <= frag_q + CNT_W'(1);
						s_q     <= end_q;
						first_q <= 1'b0;
						if (end_q == n_q) i_q <= '0;
					end else begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				BK_EMIT: begin
					i_q            <= i_q + CNT_W'(1);
					result_valid   <= 1'b1;
					line_number    <= i_q[5:0];
					page_number    <= prdata.page;
					column_number  <= prdata.column;
					y_offset       <= prdata.y;
					status         <= ST_OK;
					fragment_total <= last_i ? frag_q : '0;
					page_total     <= last_i ? page_q + CNT_W'(1) : '0;
					final_result   <= last_i;
				end
				default: ;
			endcase
		end
	end

	a_err_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_OK |-> final_result)
		else $error("error request not marked final");
	a_totals_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !final_result |-> fragment_total == '0 && page_total == '0)
		else $error("totals on a non-final request");
	a_place_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_PLACE |-> i_q < end_q && end_q <= n_q)
		else $error("placement index out of fragment");
	a_release_final: assert property (@(posedge clk) disable iff (!arst_n)
		release_set |=> result_valid && final_result)
		else $error("release without final request");
endmodule

>>> rtl/core/line_paginator.sv
// line_paginator: top level; config registers, line store, loader,
// request queue and pagination engine. Depends on lp_pkg, lp_ram,
// lp_queue, lp_front, lp_back.
//
// Use: write page_height (index 0) and columns_per_page (index 1) through
// cfg_we/cfg_index/cfg_wdata while idle. Send lines with start while busy
// is low, one per cycle. The line with last_line set closes the set; busy
// then stays high up to the cycle in which the final request is shown.
// After the closing line the engine picks up the set, then per fragment
// loads its first line, examines lines one at a time (up to and including
// the line that stops the search, or the end-of-set check; lines past a
// fragment end are examined again by the next search) and places its
// lines one by one; then it emits the lines in turn. Each request shows
// in the cycle after its emit state, on result_valid, the last flagged by
// final_result. An error gives one final request in the cycle after it
// is found. Results last one cycle each; the receiver cannot stall them.
// Reset: page_height 256.0, columns_per_page 1, empty set, not busy.
module line_paginator import lp_pkg::*; #(
	parameter int MAX_LINES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_wdata,
	input  logic [23:0] line_height,
	input  logic [23:0] space_above,
	input  logic [23:0] lead_space,
	input  logic        break_allowed,
	input  logic        force_new_column,
	input  logic        force_new_page,
	input  logic        last_line,
	output logic        result_valid,
	output logic [5:0]  line_number,
	output logic [5:0]  page_number,
	output logic [9:0]  column_number,
	output logic [23:0] y_offset,
	output logic [1:0]  status,
	output logic [6:0]  fragment_total,
	output logic [6:0]  page_total,
	output logic        final_result
);
	localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

	logic [23:0] page_height_q;
	logic [10:0] cols_q;
	logic        lwe, push, pop, q_valid, q_full, release_set;
	logic [LW-1:0] lwaddr, lraddr;
	line_word_t  lwdata, lrdata;
	run_t        run, q_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_height_q <= 24'd65536;
			cols_q        <= 11'd1;
		end else if (cfg_we) begin
			if (cfg_index == REG_COLUMNS) cols_q <= cfg_wdata[10:0];
			else page_height_q <= cfg_wdata;
		end
	end

	lp_front #(.MAX_LINES(MAX_LINES)) u_front (
		.clk, .arst_n, .start, .busy,
		.line_height, .space_above, .lead_space,
		.break_allowed, .force_new_column, .force_new_page, .last_line,
		.release_set,
		.we (lwe), .waddr (lwaddr), .wdata (lwdata),
		.push, .run
	);

	lp_ram #(.WIDTH($bits(line_word_t)), .DEPTH(MAX_LINES)) u_lines (
		.clk, .we (lwe), .waddr (lwaddr), .wdata (lwdata),
		.raddr (lraddr), .rdata (lrdata)
	);

	lp_queue u_queue (
		.clk, .arst_n, .push, .din (run), .pop,
		.valid (q_valid), .dout (q_run), .full (q_full)
	);

	lp_back #(.MAX_LINES(MAX_LINES)) u_back (
		.clk, .arst_n, .q_valid, .q_run, .pop,
		.line_raddr (lraddr), .line_rdata (lrdata),
		.page_height (page_height_q), .columns_per_page (cols_q),
		.release_set,
		.result_valid, .line_number, .page_number, .column_number,
		.y_offset, .status, .fragment_total, .page_total, .final_result
	);

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("request queue overfilled");
endmodule
